// File: hw/rtl/chalc_pkg.sv
// Package of shared types, sizes and constants for the audit log coalescer.
package chalc_pkg;

    localparam int BUFFER_DEPTH = 8;
    localparam int RING_SLOTS   = 256;

    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int SLOT_W = $clog2(RING_SLOTS);

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    localparam logic [31:0] RST_FLUSH_INTERVAL = 32'd5000;
    localparam logic [31:0] RST_FLASH_BASE     = 32'd0;
    localparam logic [7:0]  RST_BLOCK_ACTION   = 8'd1;

    localparam logic [1:0] CFG_FLUSH_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_FLASH_BASE     = 2'd1;
    localparam logic [1:0] CFG_BLOCK_ACTION   = 2'd2;

    localparam logic OP_LOG   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_DECIDE,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_DIRECT
    } t_state;

    typedef struct packed {
        logic [31:0] hash;
        logic [7:0]  rsn;
        logic [7:0]  act;
        logic [15:0] ses;
        logic [15:0] tgt;
        logic [31:0] ts;
    } t_entry;

    // Packed so that the write address sits in the lowest bits.
    typedef struct packed {
        logic [31:0] write_total;
        logic [31:0] chain_hash;
        logic [7:0]  reason;
        logic [7:0]  action;
        logic [15:0] session;
        logic [15:0] target;
        logic [31:0] timestamp;
        logic [31:0] address;
    } t_out_word;

endpackage

// File: hw/rtl/chained_hash_audit_log_coalescer.sv
// Top level of the chained-hash audit log coalescer.
// A logged event is accepted, hashed one byte at a time through the shared FNV multiplier
// over sixteen bytes, then decided; each drained entry takes a buffer read and an output
// load, and a direct write a single output load, plus any wait on the output side.
// New input waits until the event and any drain or direct write that it causes are done.
// Synchronous active-low reset clears control state and counters, but not the entry buffer.
module chained_hash_audit_log_coalescer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input words.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: now_ms[31:0], action[39:32], reason[47:40],
    // target_key[63:48], session[79:64].
    input  logic [79:0]  s_axis_tdata,
    // Fields from bit 0: opcode[0].
    input  logic         s_axis_tuser,
    // Result words, one per flash write.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: write_address[31:0], rec_timestamp[63:32], rec_target[79:64],
    // rec_session[95:80], rec_action[103:96], rec_reason[111:104],
    // rec_chain_hash[143:112], write_total[175:144].
    output logic [175:0] m_axis_tdata,
    output logic         m_axis_tlast,
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    // Configuration registers.
    logic [31:0] r_interval;
    logic [31:0] r_base;
    logic [7:0]  r_block_code;

    // Sequencer and bookkeeping.
    chalc_pkg::t_state           r_state, n_state;
    logic [3:0]                  r_step, n_step;
    logic [chalc_pkg::CNT_W-1:0] r_count, n_count;
    logic [chalc_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [chalc_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [31:0]                 r_last_flush, n_last_flush;
    logic [31:0]                 r_counter, n_counter;
    logic                        r_direct, n_direct;
    logic [31:0]                 r_last_hash, n_last_hash;

    // Captured event and running hash.
    logic [31:0] r_now, n_now;
    logic [7:0]  r_act, n_act;
    logic [7:0]  r_rsn, n_rsn;
    logic [15:0] r_tgt, n_tgt;
    logic [15:0] r_ses, n_ses;
    logic [31:0] r_prev, n_prev;
    logic [31:0] r_hash, n_hash;

    // Output register.
    logic                  r_m_valid, n_m_valid;
    logic                  r_m_last, n_m_last;
    chalc_pkg::t_out_word  r_out, n_out;

    // Entry buffer, with a registered read port.
    chalc_pkg::t_entry r_mem [chalc_pkg::BUFFER_DEPTH];
    chalc_pkg::t_entry r_rd;
    logic              mem_we;
    chalc_pkg::t_entry mem_wdata;

    logic        in_accept;
    logic        out_free;
    logic [127:0] rec_bytes;
    logic [7:0]  hash_byte;
    logic [31:0] elapsed;
    logic [chalc_pkg::CNT_W-1:0] count_inc;
    logic        idx_final;
    logic [chalc_pkg::SLOT_W-1:0] slot_inc;
    logic [31:0] addr_now;

    assign s_axis_tready = (r_state == chalc_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = r_out;

    // The sixteen hashed bytes: the record in little-endian order, two zero pad bytes,
    // then the previous entry's hash.
    assign rec_bytes = {r_prev, 16'h0000, r_rsn, r_act, r_ses, r_tgt, r_now};
    assign hash_byte = rec_bytes[{r_step, 3'b000} +: 8];

    assign elapsed   = r_now - r_last_flush;
    assign count_inc = r_count + 1'b1;
    assign idx_final = (r_idx + 1'b1) == r_count;
    assign slot_inc  = (r_slot == chalc_pkg::SLOT_W'(chalc_pkg::RING_SLOTS - 1))
                       ? '0 : r_slot + 1'b1;
    assign addr_now  = r_base + (32'(r_slot) << 4);

    // Configuration writes are taken in any cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= chalc_pkg::RST_FLUSH_INTERVAL;
            r_base       <= chalc_pkg::RST_FLASH_BASE;
            r_block_code <= chalc_pkg::RST_BLOCK_ACTION;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                chalc_pkg::CFG_FLUSH_INTERVAL: r_interval   <= i_cfg_data;
                chalc_pkg::CFG_FLASH_BASE:     r_base       <= i_cfg_data;
                chalc_pkg::CFG_BLOCK_ACTION:   r_block_code <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Buffer write and read. The read address is the drain index, so the entry is ready
    // in the cycle after the read state.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[chalc_pkg::IDX_W-1:0]] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx[chalc_pkg::IDX_W-1:0]];
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= chalc_pkg::ST_IDLE;
            r_step       <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_slot       <= '0;
            r_last_flush <= '0;
            r_counter    <= '0;
            r_direct     <= 1'b0;
            r_m_valid    <= 1'b0;
            r_m_last     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_slot       <= n_slot;
            r_last_flush <= n_last_flush;
            r_counter    <= n_counter;
            r_direct     <= n_direct;
            r_m_valid    <= n_m_valid;
            r_m_last     <= n_m_last;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_act       <= n_act;
        r_rsn       <= n_rsn;
        r_tgt       <= n_tgt;
        r_ses       <= n_ses;
        r_prev      <= n_prev;
        r_hash      <= n_hash;
        r_last_hash <= n_last_hash;
        r_out       <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_idx        = r_idx;
        n_slot       = r_slot;
        n_last_flush = r_last_flush;
        n_counter    = r_counter;
        n_direct     = r_direct;
        n_last_hash  = r_last_hash;
        n_now        = r_now;
        n_act        = r_act;
        n_rsn        = r_rsn;
        n_tgt        = r_tgt;
        n_ses        = r_ses;
        n_prev       = r_prev;
        n_hash       = r_hash;
        n_m_valid    = r_m_valid && !m_axis_tready;
        n_m_last     = r_m_last;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_wdata    = '{hash: r_hash, rsn: r_rsn, act: r_act, ses: r_ses,
                         tgt: r_tgt, ts: r_now};

        case (r_state)
            chalc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_now  = s_axis_tdata[31:0];
                    n_act  = s_axis_tdata[39:32];
                    n_rsn  = s_axis_tdata[47:40];
                    n_tgt  = s_axis_tdata[63:48];
                    n_ses  = s_axis_tdata[79:64];
                    // The chain links to the newest buffered entry, or to zero.
                    n_prev = (r_count != '0) ? r_last_hash : 32'h0;
                    n_hash = chalc_pkg::FNV_BASIS;
                    n_step = '0;
                    if (s_axis_tuser == chalc_pkg::OP_FLUSH) begin
                        // An explicit flush of an empty buffer does nothing at all.
                        if (r_count != '0) begin
                            n_counter = r_counter + 1'b1;
                            n_idx     = '0;
                            n_direct  = 1'b0;
                            n_state   = chalc_pkg::ST_DRAIN_RD;
                        end
                    end else begin
                        n_state = chalc_pkg::ST_HASH;
                    end
                end
            end

            chalc_pkg::ST_HASH: begin
                n_hash = (r_hash ^ {24'h000000, hash_byte}) * chalc_pkg::FNV_PRIME;
                n_step = r_step + 1'b1;
                if (r_step == 4'd15) begin
                    n_state = chalc_pkg::ST_DECIDE;
                end
            end

            chalc_pkg::ST_DECIDE: begin
                if (r_act == r_block_code) begin
                    // Blocking actions drain what is buffered, then go out directly.
                    if (r_count != '0) begin
                        n_counter = r_counter + 1'b1;
                        n_idx     = '0;
                        n_direct  = 1'b1;
                        n_state   = chalc_pkg::ST_DRAIN_RD;
                    end else begin
                        n_state = chalc_pkg::ST_DIRECT;
                    end
                end else begin
                    mem_we      = 1'b1;
                    n_count     = count_inc;
                    n_last_hash = r_hash;
                    if (count_inc >= chalc_pkg::CNT_W'(chalc_pkg::BUFFER_DEPTH) ||
                        elapsed >= r_interval) begin
                        n_counter = r_counter + 1'b1;
                        n_idx     = '0;
                        n_direct  = 1'b0;
                        n_state   = chalc_pkg::ST_DRAIN_RD;
                    end else begin
                        n_state = chalc_pkg::ST_IDLE;
                    end
                end
            end

            chalc_pkg::ST_DRAIN_RD: begin
                n_state = chalc_pkg::ST_DRAIN_OUT;
            end

            chalc_pkg::ST_DRAIN_OUT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_last  = idx_final && !r_direct;
                    n_out     = '{write_total: r_counter, chain_hash: r_rd.hash,
                                  reason: r_rd.rsn, action: r_rd.act, session: r_rd.ses,
                                  target: r_rd.tgt, timestamp: r_rd.ts, address: addr_now};
                    n_slot    = slot_inc;
                    if (idx_final) begin
                        n_count      = '0;
                        n_last_flush = r_now;
                        n_state      = r_direct ? chalc_pkg::ST_DIRECT : chalc_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = chalc_pkg::ST_DRAIN_RD;
                    end
                end
            end

            chalc_pkg::ST_DIRECT: begin
                if (out_free) begin
                    n_counter = r_counter + 1'b1;
                    n_m_valid = 1'b1;
                    n_m_last  = 1'b1;
                    n_out     = '{write_total: r_counter + 1'b1, chain_hash: r_hash,
                                  reason: r_rsn, action: r_act, session: r_ses,
                                  target: r_tgt, timestamp: r_now, address: addr_now};
                    n_slot    = slot_inc;
                    n_direct  = 1'b0;
                    n_state   = chalc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = chalc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/chalc_checker.sv
// Port-level checker for the audit log coalescer, with its bind statement.
module chalc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // A logged event is hashed over many cycles, so no word is taken just after it.
    a_log_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken during event hashing");

    // While writes of one input remain, the block takes no new input.
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready before the last write of a run");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind chained_hash_audit_log_coalescer chalc_checker u_chalc_checker (.*);
